// ===== rtl/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the segment sum accumulator.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int unsigned MaxSegmentsDef = 256;
  localparam int unsigned MaxRowDef      = 16;

  // width of the epoch tag kept with each sum entry; tag zero is never current
  localparam int unsigned TagW = 4;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ACCUM = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_SEG_ERR = 2'd1;
  localparam logic [1:0] STAT_COL_ERR = 2'd2;

  localparam logic REG_NUM_SEGMENTS = 1'b0;
  localparam logic REG_ROW_SIZE     = 1'b1;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_CUR,
    RES_ADD
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     decode;
    logic     epoch_inc;
    logic     epoch_rst;
    logic     sweep;
    logic     mem_rd;
    logic     add_start;
    logic     mem_wr;
    logic     res_load;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       err;
    logic       epoch_full;
    logic       sweep_last;
    logic       add_done;
  } ctrl_stat_t;

endpackage

// ===== rtl/ssa_fpadd.sv =====
// ----------------------------------------------------------------------------
// ssa_fpadd
// Four-stage float32 adder, round to nearest even: align, add,
// leading-zero count, normalize and round. NaN results are canonical.
// ----------------------------------------------------------------------------
module ssa_fpadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  import ssa_pkg::*;

  logic [3:0] vld_q;

  // stage 1: unpack, specials, swap, align
  logic [7:0]  ea, eb_in, eea, eeb, ebig, esml, dexp;
  logic [23:0] ma, mb, mbig, msml;
  logic        nan_a, nan_b, inf_a, inf_b, a_ge, sgn_big;
  logic        spec_d;
  logic [31:0] spec_val_d;
  logic [26:0] sm_full, sm_sh;
  logic        sticky;

  logic        s1_sub_q, s1_sgn_q, s1_spec_q;
  logic [31:0] s1_spec_val_q;
  logic [7:0]  s1_e_q;
  logic [27:0] s1_mb_q, s1_ms_q;

  always_comb begin
    ea    = a_i[30:23];
    eb_in = b_i[30:23];
    nan_a = (ea == 8'hFF) && (a_i[22:0] != 23'd0);
    nan_b = (eb_in == 8'hFF) && (b_i[22:0] != 23'd0);
    inf_a = (ea == 8'hFF) && (a_i[22:0] == 23'd0);
    inf_b = (eb_in == 8'hFF) && (b_i[22:0] == 23'd0);
    spec_d     = 1'b1;
    spec_val_d = CANON_NAN;
    if (nan_a || nan_b) begin
      spec_val_d = CANON_NAN;
    end else if (inf_a && inf_b) begin
      spec_val_d = (a_i[31] != b_i[31]) ? CANON_NAN : a_i;
    end else if (inf_a) begin
      spec_val_d = a_i;
    end else if (inf_b) begin
      spec_val_d = b_i;
    end else begin
      spec_d = 1'b0;
    end
    ma   = {ea != 8'd0, a_i[22:0]};
    mb   = {eb_in != 8'd0, b_i[22:0]};
    eea  = (ea == 8'd0) ? 8'd1 : ea;
    eeb  = (eb_in == 8'd0) ? 8'd1 : eb_in;
    a_ge = a_i[30:0] >= b_i[30:0];
    ebig = a_ge ? eea : eeb;
    esml = a_ge ? eeb : eea;
    mbig = a_ge ? ma : mb;
    msml = a_ge ? mb : ma;
    sgn_big = a_ge ? a_i[31] : b_i[31];
    dexp    = ebig - esml;
    sm_full = {msml, 3'b000};
    if (dexp >= 8'd27) begin
      sm_sh  = '0;
      sticky = msml != 24'd0;
    end else begin
      sm_sh  = sm_full >> dexp;
      sticky = (sm_full & ~(27'h7FF_FFFF << dexp)) != 27'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_sub_q      <= a_i[31] ^ b_i[31];
      s1_sgn_q      <= sgn_big;
      s1_spec_q     <= spec_d;
      s1_spec_val_q <= spec_val_d;
      s1_e_q        <= ebig;
      s1_mb_q       <= {1'b0, mbig, 3'b000};
      s1_ms_q       <= {1'b0, sm_sh[26:1], sm_sh[0] | sticky};
    end
  end

  // stage 2: magnitude add or subtract
  logic        s2_sub_q, s2_sgn_q, s2_spec_q;
  logic [31:0] s2_spec_val_q;
  logic [7:0]  s2_e_q;
  logic [27:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      s2_sub_q      <= s1_sub_q;
      s2_sgn_q      <= s1_sgn_q;
      s2_spec_q     <= s1_spec_q;
      s2_spec_val_q <= s1_spec_val_q;
      s2_e_q        <= s1_e_q;
      s2_sum_q      <= s1_sub_q ? (s1_mb_q - s1_ms_q) : (s1_mb_q + s1_ms_q);
    end
  end

  // stage 3: leading-zero count, clamped so the exponent stays at one or more
  logic [4:0]  lz;
  logic [4:0]  sh_d;
  logic        s3_sub_q, s3_sgn_q, s3_spec_q, s3_carry_q, s3_zero_q;
  logic [31:0] s3_spec_val_q;
  logic [7:0]  s3_e_q;
  logic [27:0] s3_sum_q;
  logic [4:0]  s3_sh_q;

  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s2_sum_q[i]) lz = 5'(26 - i);
    end
    sh_d = ({3'b000, lz} > (s2_e_q - 8'd1)) ? 5'(s2_e_q - 8'd1) : lz;
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      s3_sub_q      <= s2_sub_q;
      s3_sgn_q      <= s2_sgn_q;
      s3_spec_q     <= s2_spec_q;
      s3_spec_val_q <= s2_spec_val_q;
      s3_e_q        <= s2_e_q;
      s3_sum_q      <= s2_sum_q;
      s3_carry_q    <= s2_sum_q[27];
      s3_zero_q     <= s2_sum_q == 28'd0;
      s3_sh_q       <= sh_d;
    end
  end

  // stage 4: normalize and round; rounding carries into the exponent field
  logic [26:0] norm;
  logic [8:0]  exp9, expf;
  logic        rnd;
  logic [30:0] packed_mag;
  logic [31:0] res_d;
  logic [31:0] res_q;

  always_comb begin
    if (s3_carry_q) begin
      norm = {s3_sum_q[27:2], s3_sum_q[1] | s3_sum_q[0]};
      exp9 = {1'b0, s3_e_q} + 9'd1;
    end else begin
      norm = s3_sum_q[26:0] << s3_sh_q;
      exp9 = {1'b0, s3_e_q} - {4'd0, s3_sh_q};
    end
    expf       = norm[26] ? exp9 : 9'd0;
    rnd        = norm[2] & (norm[1] | norm[0] | norm[3]);
    packed_mag = {expf[7:0], norm[25:3]} + {30'd0, rnd};
    if (s3_spec_q) begin
      res_d = s3_spec_val_q;
    end else if (s3_zero_q) begin
      res_d = {~s3_sub_q & s3_sgn_q, 31'd0};
    end else if (expf >= 9'd255) begin
      res_d = {s3_sgn_q, 8'hFF, 23'd0};
    end else begin
      res_d = {s3_sgn_q, packed_mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  assign done_o = vld_q[3];
  assign res_o  = res_q;

endmodule

// ===== rtl/ssa_datapath.sv =====
// ----------------------------------------------------------------------------
// ssa_datapath
// Config registers, item decode, tagged sum memory, epoch counter,
// clearing sweep counter, float adder and result registers.
// ----------------------------------------------------------------------------
module ssa_datapath #(
  parameter int unsigned MAX_SEGMENTS = ssa_pkg::MaxSegmentsDef,
  parameter int unsigned MAX_ROW      = ssa_pkg::MaxRowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [8:0]         cfg_wdata_i,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] segment_id_i,
  input  logic [3:0]         column_i,
  input  logic [31:0]        value_i,
  input  ssa_pkg::ctrl_cmd_t cmd_i,
  output ssa_pkg::ctrl_stat_t stat_o,
  output logic [31:0]        sum_value_o,
  output logic [1:0]         status_o
);
  import ssa_pkg::*;

  localparam int unsigned Entries = MAX_SEGMENTS * MAX_ROW;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned WordW   = TagW + 32;

  logic [8:0] num_seg_q;
  logic [4:0] row_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_seg_q  <= 9'd256;
      row_size_q <= 5'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NUM_SEGMENTS) num_seg_q  <= cfg_wdata_i;
      if (cfg_idx_i == REG_ROW_SIZE)     row_size_q <= cfg_wdata_i[4:0];
    end
  end

  // item capture
  logic [1:0]  mode_q;
  logic [31:0] seg_q;
  logic [3:0]  col_q;
  logic [31:0] value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      seg_q   <= segment_id_i;
      col_q   <= column_i;
      value_q <= value_i;
    end
  end

  // range checks and address
  logic [31:0] seg_lim, row_lim, addr_full;
  logic [1:0]  stat_d;
  logic [1:0]  stat_q;
  logic [AddrW-1:0] addr_q;

  always_comb begin
    seg_lim = (32'(num_seg_q) > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS) : 32'(num_seg_q);
    row_lim = (32'(row_size_q) > 32'(MAX_ROW)) ? 32'(MAX_ROW) : 32'(row_size_q);
    addr_full = seg_q * 32'(MAX_ROW) + 32'(col_q);
    stat_d = STAT_OK;
    if (mode_q == MODE_ACCUM || mode_q == MODE_READ) begin
      if (seg_q[31] || seg_q >= seg_lim) begin
        stat_d = STAT_SEG_ERR;
      end else if (32'(col_q) >= row_lim) begin
        stat_d = STAT_COL_ERR;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      stat_q <= stat_d;
      addr_q <= addr_full[AddrW-1:0];
    end
  end

  // epoch: an entry is valid only when its tag equals the current epoch
  logic [TagW-1:0]  epoch_q;
  logic [AddrW-1:0] sweep_q;
  logic             sweep_last;

  assign sweep_last = 32'(sweep_q) == 32'(Entries - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      sweep_q <= '0;
    end else begin
      if (cmd_i.epoch_rst) begin
        epoch_q <= TagW'(1);
      end else if (cmd_i.epoch_inc) begin
        epoch_q <= epoch_q + TagW'(1);
      end
      if (cmd_i.sweep) sweep_q <= sweep_last ? '0 : sweep_q + AddrW'(1);
    end
  end

  // sum memory, tag in the upper bits
  logic [WordW-1:0] mem [Entries];
  logic [WordW-1:0] rdata_q;
  logic             add_done;
  logic [31:0]      add_res;
  logic [31:0]      cur;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mem[sweep_q] <= '0;
    end else if (cmd_i.mem_wr) begin
      mem[addr_q] <= {epoch_q, add_res};
    end
    if (cmd_i.mem_rd) rdata_q <= mem[addr_q];
  end

  assign cur = (rdata_q[WordW-1 -: TagW] == epoch_q) ? rdata_q[31:0] : 32'd0;

  ssa_fpadd u_fpadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.add_start),
    .a_i     (cur),
    .b_i     (value_q),
    .done_o  (add_done),
    .res_o   (add_res)
  );

  logic [31:0] sum_q;
  logic [1:0]  status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= stat_q;
      case (cmd_i.res_sel)
        RES_CUR: sum_q <= cur;
        RES_ADD: sum_q <= add_res;
        default: sum_q <= 32'd0;
      endcase
    end
  end

  assign sum_value_o = sum_q;
  assign status_o    = status_q;

  assign stat_o.mode       = mode_q;
  assign stat_o.err        = stat_q != STAT_OK;
  assign stat_o.epoch_full = epoch_q == '1;
  assign stat_o.sweep_last = sweep_last;
  assign stat_o.add_done   = add_done;

endmodule

// ===== rtl/ssa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssa_ctrl
// Sequencer: clearing pass, decode, memory read, add, write back, result.
// ----------------------------------------------------------------------------
module ssa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ssa_pkg::ctrl_stat_t stat_i,
  output ssa_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import ssa_pkg::*;

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DEC    = 4'd2;
  localparam logic [3:0] ST_EVAL   = 4'd3;
  localparam logic [3:0] ST_READ   = 4'd4;
  localparam logic [3:0] ST_CUR    = 4'd5;
  localparam logic [3:0] ST_ADD    = 4'd6;
  localparam logic [3:0] ST_SWEEP  = 4'd7;
  localparam logic [3:0] ST_RESULT = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_ZERO;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.epoch_rst = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd_o.decode = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat_i.mode == MODE_CLEAR) begin
          if (stat_i.epoch_full) begin
            state_d = ST_SWEEP;
          end else begin
            cmd_o.epoch_inc = 1'b1;
            cmd_o.res_load  = 1'b1;
            state_d = ST_RESULT;
          end
        end else if (stat_i.err ||
                     (stat_i.mode != MODE_ACCUM && stat_i.mode != MODE_READ)) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d = ST_CUR;
      end
      ST_CUR: begin
        if (stat_i.mode == MODE_READ) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_CUR;
          state_d = ST_RESULT;
        end else begin
          cmd_o.add_start = 1'b1;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (stat_i.add_done) begin
          cmd_o.mem_wr   = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ADD;
          state_d = ST_RESULT;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.epoch_rst = 1'b1;
          cmd_o.res_load  = 1'b1;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = state_q == ST_RESULT;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("transfer not followed by busy");

  a_wr_one_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.sweep && (cmd_o.mem_wr || cmd_o.mem_rd)))
    else $error("sweep overlaps item access");

  a_add_then_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> stat_i.add_done) else $error("write back without add result");

endmodule

// ===== rtl/segment_sum_accumulator.sv =====
// ----------------------------------------------------------------------------
// segment_sum_accumulator
// Float32 scatter-add engine for an unsorted segment sum.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o low; its single result
// appears on sum_value_o/status_o for exactly one cycle with done_o high and
// must be taken then, since the receiver cannot stall. After reset the block
// runs a clearing pass over all MAX_SEGMENTS*MAX_ROW entries (4096 by
// default) with busy_o high. Error items, unused modes and a normal clear
// go from decode straight to the result; read adds a memory read, and
// accumulate adds the memory read, the four-stage float adder and the write
// back. The next item can be taken in the cycle after the result. Every
// fifteenth clear wraps the entry epoch tag and reruns the clearing pass
// over all entries.
// ----------------------------------------------------------------------------
module segment_sum_accumulator #(
  parameter int unsigned MAX_SEGMENTS = ssa_pkg::MaxSegmentsDef,
  parameter int unsigned MAX_ROW      = ssa_pkg::MaxRowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [8:0]         cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] segment_id_i,
  input  logic [3:0]         column_i,
  input  logic [31:0]        value_i,
  output logic               done_o,
  output logic [31:0]        sum_value_o,
  output logic [1:0]         status_o
);
  import ssa_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  ssa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ssa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_ROW      (MAX_ROW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .segment_id_i (segment_id_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sum_value_o  (sum_value_o),
    .status_o     (status_o)
  );

endmodule
